// File: design/tqvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap quad vertex generator package
// Shared types, register codes and helpers for the tile-to-quad pipeline.
// ----------------------------------------------------------------------------
package tqvg_pkg;

  localparam int unsigned TileW        = 12;
  localparam int unsigned PosW         = 8;
  localparam int unsigned RegW         = 9;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned MaxTileValue = 4095;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgGridCols = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOutTileW = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOutTileH = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSrcTileW = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSrcTileH = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTexCols  = 3'd5;

  // corner codes, emitted in this order
  localparam logic [1:0] CornerTl = 2'd0;
  localparam logic [1:0] CornerTr = 2'd1;
  localparam logic [1:0] CornerBr = 2'd2;
  localparam logic [1:0] CornerBl = 2'd3;

  typedef struct packed {
    logic [11:0] tile_value;
    logic        start_of_map;
  } tile_req_t;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] tex_x;
    logic [20:0] tex_y;
    logic [1:0]  corner;
    logic        last_corner;
  } vertex_t;

  typedef struct packed {
    logic [RegW-1:0] grid_cols;
    logic [RegW-1:0] out_tile_w;
    logic [RegW-1:0] out_tile_h;
    logic [RegW-1:0] src_tile_w;
    logic [RegW-1:0] src_tile_h;
    logic [RegW-1:0] tex_cols;
  } cfg_t;

  // one queued tile: texture index (value minus one) and its grid cell
  typedef struct packed {
    logic [TileW-1:0] tile_idx;
    logic [PosW-1:0]  col;
    logic [PosW-1:0]  row;
  } tile_job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkEmit
  } back_state_e;

  // clamp a register to the range 1..256
  function automatic logic [RegW-1:0] eff_dim(input logic [RegW-1:0] r);
    logic [RegW-1:0] v;
    v = r;
    if (r == '0) begin
      v = 9'd1;
    end else if (r > 9'd256) begin
      v = 9'd256;
    end
    return v;
  endfunction

endpackage

// File: design/tilemap_quad_vertex_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap quad vertex generator
// Turns a row-major stream of tile numbers into four textured quad corners.
// ----------------------------------------------------------------------------
// The front end takes one tile request per cycle while the job queue has
// room; empty tiles only advance the grid position and are absorbed there.
// Each non-empty tile goes through the back end in order: it is picked from
// the queue, the one-bit-per-cycle divider splits its texture index into row
// and column, a hand-over step follows, and the four corners are emitted from
// the output register, one vertex a cycle while the receiver is ready. The
// next tile is picked only after the last corner of this one is loaded; up to
// QUEUE_DEPTH tiles wait between the two halves. The user must write the
// registers only while no tile is in flight; the block does not enforce it.
module tilemap_quad_vertex_generator_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tqvg_pkg::tile_req_t            in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tqvg_pkg::vertex_t              out_vtx_o,
  input  logic                           cfg_we_i,
  input  logic [tqvg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tqvg_pkg::RegW-1:0]      cfg_wdata_i
);

  tqvg_pkg::cfg_t      cfg_q, cfg_d;
  tqvg_pkg::tile_job_t push_job, head_job;
  logic                q_push, q_pop, q_full, q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tqvg_pkg::CfgGridCols: cfg_d.grid_cols  = cfg_wdata_i;
        tqvg_pkg::CfgOutTileW: cfg_d.out_tile_w = cfg_wdata_i;
        tqvg_pkg::CfgOutTileH: cfg_d.out_tile_h = cfg_wdata_i;
        tqvg_pkg::CfgSrcTileW: cfg_d.src_tile_w = cfg_wdata_i;
        tqvg_pkg::CfgSrcTileH: cfg_d.src_tile_h = cfg_wdata_i;
        tqvg_pkg::CfgTexCols:  cfg_d.tex_cols   = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols  <= 9'd40;
      cfg_q.out_tile_w <= 9'd16;
      cfg_q.out_tile_h <= 9'd16;
      cfg_q.src_tile_w <= 9'd16;
      cfg_q.src_tile_h <= 9'd16;
      cfg_q.tex_cols   <= 9'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tqvg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .grid_cols_i (cfg_q.grid_cols),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  tqvg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .pop_i       (q_pop),
    .pop_data_o  (head_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  tqvg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_vtx_o   (out_vtx_o)
  );

`ifndef ASSERT_OFF
  // the queue must never be offered a tile it cannot hold
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("tile pushed into full queue");

  // corners of one tile follow without a gap once the first is taken
  a_corner_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_vtx_o.last_corner) |=> out_valid_o)
    else $error("gap inside a vertex burst");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_vtx_o.last_corner == (out_vtx_o.corner == tqvg_pkg::CornerBl)))
    else $error("last corner flag does not match corner");

  // after a non-last corner is taken the next one is its successor
  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_vtx_o.last_corner) |=>
    (out_vtx_o.corner == $past(out_vtx_o.corner) + 2'd1))
    else $error("corner order broken");
`endif

endmodule

// File: design/tqvg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap front end
// Accepts tile requests, tracks the grid cell and queues non-empty tiles.
// ----------------------------------------------------------------------------
module tqvg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tqvg_pkg::tile_req_t         in_req_i,
  input  logic [tqvg_pkg::RegW-1:0]   grid_cols_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output tqvg_pkg::tile_job_t         q_job_o
);

  logic [tqvg_pkg::PosW-1:0] col_q, col_d, row_q, row_d;
  logic [tqvg_pkg::PosW-1:0] col_now, row_now;
  logic [tqvg_pkg::PosW:0]   col_inc;
  logic [tqvg_pkg::TileW:0]  tv_ext;
  logic [tqvg_pkg::TileW-1:0] tv_clamp;
  logic                      accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // start of map clears the position before this tile uses it
  assign col_now = in_req_i.start_of_map ? '0 : col_q;
  assign row_now = in_req_i.start_of_map ? '0 : row_q;
  assign col_inc = {1'b0, col_now} + 9'd1;

  assign tv_ext   = {1'b0, in_req_i.tile_value};
  assign tv_clamp = (tv_ext > 13'(tqvg_pkg::MaxTileValue)) ?
                    12'(tqvg_pkg::MaxTileValue) : in_req_i.tile_value;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= tqvg_pkg::eff_dim(grid_cols_i)) begin
        col_d = '0;
        row_d = (row_now == 8'd255) ? row_now : row_now + 8'd1;
      end else begin
        col_d = col_inc[tqvg_pkg::PosW-1:0];
        row_d = row_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // drop empty tiles here: they only move the position
  assign q_push_o         = accept && (in_req_i.tile_value != '0);
  assign q_job_o.tile_idx = tv_clamp - 12'd1;
  assign q_job_o.col      = col_now;
  assign q_job_o.row      = row_now;

endmodule

// File: design/tqvg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile job queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module tqvg_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tqvg_pkg::tile_job_t push_data_i,
  input  logic                pop_i,
  output tqvg_pkg::tile_job_t pop_data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  tqvg_pkg::tile_job_t mem_q [DEPTH];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/tqvg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture index divider
// Restoring divider, one quotient bit per cycle, for texture row and column.
// ----------------------------------------------------------------------------
module tqvg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tqvg_pkg::TileW-1:0] dividend_i,
  input  logic [tqvg_pkg::RegW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tqvg_pkg::TileW-1:0] quot_o,
  output logic [tqvg_pkg::RegW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(tqvg_pkg::TileW + 1);

  logic                       busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tqvg_pkg::TileW-1:0] quot_q, quot_d;
  logic [tqvg_pkg::RegW-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [tqvg_pkg::RegW:0]    rem_sh, rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_q, quot_q[tqvg_pkg::TileW-1]};
  assign fits    = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in RegW bits
      rem_d  = fits ? rem_sub[tqvg_pkg::RegW-1:0] : rem_sh[tqvg_pkg::RegW-1:0];
      quot_d = {quot_q[tqvg_pkg::TileW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(tqvg_pkg::TileW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: design/tqvg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap back end
// Takes queued tiles, divides the texture index and emits four vertices.
// ----------------------------------------------------------------------------
module tqvg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tqvg_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  tqvg_pkg::tile_job_t q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tqvg_pkg::vertex_t   out_vtx_o
);

  tqvg_pkg::back_state_e       state_q, state_d;
  logic [1:0]                  corner_q, corner_d;
  logic [tqvg_pkg::PosW-1:0]   col_q, row_q;
  logic                        out_valid_q, out_valid_d;
  tqvg_pkg::vertex_t           out_q, vtx;
  logic                        div_done, load;
  logic [tqvg_pkg::TileW-1:0]  trow;
  logic [tqvg_pkg::RegW-1:0]   tcol;
  logic                        dx, dy;
  logic [17:0]                 px_full, py_full, tx_full;
  logic [21:0]                 ty_full;

  tqvg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (q_pop_o),
    .dividend_i (q_job_i.tile_idx),
    .divisor_i  (tqvg_pkg::eff_dim(cfg_i.tex_cols)),
    .done_o     (div_done),
    .quot_o     (trow),
    .rem_o      (tcol)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      tqvg_pkg::BkIdle: begin
        if (!q_empty_i) begin
          state_d = tqvg_pkg::BkDiv;
        end
      end
      tqvg_pkg::BkDiv: begin
        if (div_done) begin
          state_d = tqvg_pkg::BkEmit;
        end
      end
      tqvg_pkg::BkEmit: begin
        if (load && corner_q == tqvg_pkg::CornerBl) begin
          state_d = tqvg_pkg::BkIdle;
        end
      end
      default: state_d = tqvg_pkg::BkIdle;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      tqvg_pkg::BkIdle: q_pop_o = !q_empty_i;
      tqvg_pkg::BkEmit: load = !out_valid_q || out_ready_i;
      default: begin
        q_pop_o = 1'b0;
        load    = 1'b0;
      end
    endcase
  end

  assign corner_d = (state_q == tqvg_pkg::BkDiv) ? tqvg_pkg::CornerTl :
                    load ? corner_q + 2'd1 : corner_q;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // corner offsets
  assign dx = (corner_q == tqvg_pkg::CornerTr) || (corner_q == tqvg_pkg::CornerBr);
  assign dy = (corner_q == tqvg_pkg::CornerBr) || (corner_q == tqvg_pkg::CornerBl);

  assign px_full = 18'({1'b0, col_q} + {8'd0, dx}) *
                   18'(tqvg_pkg::eff_dim(cfg_i.out_tile_w));
  assign py_full = 18'({1'b0, row_q} + {8'd0, dy}) *
                   18'(tqvg_pkg::eff_dim(cfg_i.out_tile_h));
  assign tx_full = 18'(tcol + {8'd0, dx}) *
                   18'(tqvg_pkg::eff_dim(cfg_i.src_tile_w));
  assign ty_full = 22'({1'b0, trow} + {12'd0, dy}) *
                   22'(tqvg_pkg::eff_dim(cfg_i.src_tile_h));

  always_comb begin
    vtx.pos_x       = px_full[16:0];
    vtx.pos_y       = py_full[16:0];
    vtx.tex_x       = tx_full[16:0];
    vtx.tex_y       = ty_full[20:0];
    vtx.corner      = corner_q;
    vtx.last_corner = (corner_q == tqvg_pkg::CornerBl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqvg_pkg::BkIdle;
      corner_q    <= tqvg_pkg::CornerTl;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      col_q <= q_job_i.col;
      row_q <= q_job_i.row;
    end
    if (load) begin
      out_q <= vtx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_vtx_o   = out_q;

endmodule

// File: sim/tilemap_quad_vertex_generator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap quad vertex generator checker
// Watches the tile request, vertex and register write channels, keeps its own
// grid position and register copy, predicts the four corners of every
// non-empty tile and compares each vertex that leaves the block, in order.
// ----------------------------------------------------------------------------
module tilemap_quad_vertex_generator_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  tqvg_pkg::tile_req_t          in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  tqvg_pkg::vertex_t            out_vtx_i,
  input  logic                         cfg_we_i,
  input  logic [tqvg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tqvg_pkg::RegW-1:0]    cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  vtx_checked_o
);

  localparam int unsigned PrintCap = 40;

  tqvg_pkg::cfg_t    regs;
  logic [7:0]        grid_col;
  logic [7:0]        grid_row;
  tqvg_pkg::vertex_t corner_q[$];
  int unsigned       fail_count;
  int unsigned       vtx_checked;

  // registers outside 1..256 act as the nearest bound
  function automatic int unsigned dim_of(input logic [tqvg_pkg::RegW-1:0] r);
    int unsigned d;
    d = 32'(r);
    if (d == 0) begin
      d = 1;
    end else if (d > 256) begin
      d = 256;
    end
    return d;
  endfunction

  function automatic void step_grid();
    int unsigned nxt;
    nxt = grid_col + 1;
    if (nxt >= dim_of(regs.grid_cols)) begin
      grid_col = '0;
      if (grid_row != 8'd255) begin
        grid_row = grid_row + 8'd1;
      end
    end else begin
      grid_col = 8'(nxt);
    end
  endfunction

  function automatic void predict_quad(input tqvg_pkg::tile_req_t req);
    logic [1:0]        codes [4];
    int unsigned       tv, t, tc, tcol, trow, dx, dy, k;
    tqvg_pkg::vertex_t v;
    codes[0] = tqvg_pkg::CornerTl;
    codes[1] = tqvg_pkg::CornerTr;
    codes[2] = tqvg_pkg::CornerBr;
    codes[3] = tqvg_pkg::CornerBl;
    if (req.start_of_map) begin
      grid_col = '0;
      grid_row = '0;
    end
    tv = 32'(req.tile_value);
    if (tv != 0) begin
      if (tv > tqvg_pkg::MaxTileValue) begin
        tv = tqvg_pkg::MaxTileValue;
      end
      t    = tv - 1;
      tc   = dim_of(regs.tex_cols);
      tcol = t % tc;
      trow = t / tc;
      for (k = 0; k < 4; k++) begin
        dx = (k == 1 || k == 2) ? 1 : 0;
        dy = (k >= 2) ? 1 : 0;
        v.pos_x       = 17'((grid_col + dx) * dim_of(regs.out_tile_w));
        v.pos_y       = 17'((grid_row + dy) * dim_of(regs.out_tile_h));
        v.tex_x       = 17'((tcol + dx) * dim_of(regs.src_tile_w));
        v.tex_y       = 21'((trow + dy) * dim_of(regs.src_tile_h));
        v.corner      = codes[k];
        v.last_corner = (k == 3);
        corner_q.push_back(v);
      end
    end
    step_grid();
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PrintCap) begin
      $display("%0t ns: vertex mismatch:%s", $time, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tqvg_pkg::vertex_t got, want;
    string             diffs;
    if (!rst_ni) begin
      regs.grid_cols  = 9'd40;
      regs.out_tile_w = 9'd16;
      regs.out_tile_h = 9'd16;
      regs.src_tile_w = 9'd16;
      regs.src_tile_h = 9'd16;
      regs.tex_cols   = 9'd16;
      grid_col        = '0;
      grid_row        = '0;
      corner_q.delete();
      fail_count      = 0;
      vtx_checked     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tqvg_pkg::CfgGridCols: regs.grid_cols  = cfg_wdata_i;
          tqvg_pkg::CfgOutTileW: regs.out_tile_w = cfg_wdata_i;
          tqvg_pkg::CfgOutTileH: regs.out_tile_h = cfg_wdata_i;
          tqvg_pkg::CfgSrcTileW: regs.src_tile_w = cfg_wdata_i;
          tqvg_pkg::CfgSrcTileH: regs.src_tile_h = cfg_wdata_i;
          tqvg_pkg::CfgTexCols:  regs.tex_cols   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_quad(in_req_i);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_vtx_i;
        if (corner_q.size() == 0) begin
          report_mismatch($sformatf(" unexpected vertex corner %0d at %0d,%0d",
                                    got.corner, got.pos_x, got.pos_y));
        end else begin
          want  = corner_q.pop_front();
          diffs = "";
          if (got.pos_x !== want.pos_x)
            diffs = {diffs, $sformatf(" pos_x %0d/%0d", got.pos_x, want.pos_x)};
          if (got.pos_y !== want.pos_y)
            diffs = {diffs, $sformatf(" pos_y %0d/%0d", got.pos_y, want.pos_y)};
          if (got.tex_x !== want.tex_x)
            diffs = {diffs, $sformatf(" tex_x %0d/%0d", got.tex_x, want.tex_x)};
          if (got.tex_y !== want.tex_y)
            diffs = {diffs, $sformatf(" tex_y %0d/%0d", got.tex_y, want.tex_y)};
          if (got.corner !== want.corner)
            diffs = {diffs, $sformatf(" corner %0d/%0d", got.corner, want.corner)};
          if (got.last_corner !== want.last_corner)
            diffs = {diffs, $sformatf(" last %0b/%0b", got.last_corner,
                                      want.last_corner)};
          if (diffs != "") begin
            report_mismatch({diffs, " (got/expected)"});
          end
          vtx_checked++;
        end
      end
    end
    fail_count_o  <= fail_count;
    pending_o     <= corner_q.size();
    vtx_checked_o <= vtx_checked;
  end

endmodule

// File: sim/tilemap_quad_vertex_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap quad vertex generator testbench
// Drives tile requests under a series of register settings and idling
// patterns, including a long output hold-off, and leaves the vertex checking to the
// checker instance beside the block.
// ----------------------------------------------------------------------------
module tilemap_quad_vertex_generator_unit_test;

  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned WatchdogLimit = 6000;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned PhaseItems    = 19;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready;
  tqvg_pkg::tile_req_t          in_req;
  logic                         out_valid;
  logic                         out_ready;
  tqvg_pkg::vertex_t            out_vtx;
  logic                         cfg_we;
  logic [tqvg_pkg::CfgIdxW-1:0] cfg_idx;
  logic [tqvg_pkg::RegW-1:0]    cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned vtx_checked;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_go;
  logic        hold_taken;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned tiles_sent;
  int unsigned cfg_loads;

  tilemap_quad_vertex_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_vtx_o   (out_vtx),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tilemap_quad_vertex_generator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_vtx_i     (out_vtx),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .vtx_checked_o (vtx_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // vertex receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      hold_taken <= 1'b0;
      hold_left  <= 0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no request moved for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one tile, hold it until taken; valid stays high for the next one unless an idle gap is drawn
  task automatic send_tile(input logic [tqvg_pkg::TileW-1:0] value, input logic start);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid               <= 1'b1;
    in_req.tile_value      <= value;
    in_req.start_of_map    <= start;
    do @(posedge clk_i); while (!in_ready);
    tiles_sent++;
  endtask

  // drop valid, wait for every vertex, then let empty tiles settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_config(input tqvg_pkg::cfg_t c);
    logic [tqvg_pkg::CfgIdxW-1:0] codes [6];
    logic [tqvg_pkg::RegW-1:0]    vals  [6];
    int                           i;
    codes[0] = tqvg_pkg::CfgGridCols;  vals[0] = c.grid_cols;
    codes[1] = tqvg_pkg::CfgOutTileW;  vals[1] = c.out_tile_w;
    codes[2] = tqvg_pkg::CfgOutTileH;  vals[2] = c.out_tile_h;
    codes[3] = tqvg_pkg::CfgSrcTileW;  vals[3] = c.src_tile_w;
    codes[4] = tqvg_pkg::CfgSrcTileH;  vals[4] = c.src_tile_h;
    codes[5] = tqvg_pkg::CfgTexCols;   vals[5] = c.tex_cols;
    for (i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= codes[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cfg_loads++;
  endtask

  function automatic tqvg_pkg::cfg_t uniform_cfg(input logic [tqvg_pkg::RegW-1:0] v);
    tqvg_pkg::cfg_t c;
    c.grid_cols  = v;
    c.out_tile_w = v;
    c.out_tile_h = v;
    c.src_tile_w = v;
    c.src_tile_h = v;
    c.tex_cols   = v;
    return c;
  endfunction

  function automatic tqvg_pkg::cfg_t pick_config(input int unsigned phase);
    tqvg_pkg::cfg_t c;
    c.grid_cols  = 9'($urandom_range(1, 256));
    c.out_tile_w = 9'($urandom_range(1, 256));
    c.out_tile_h = 9'($urandom_range(1, 256));
    c.src_tile_w = 9'($urandom_range(1, 256));
    c.src_tile_h = 9'($urandom_range(1, 256));
    c.tex_cols   = 9'($urandom_range(1, 256));
    case (phase)
      0: begin
        c = uniform_cfg(9'd16);
        c.grid_cols = 9'd40;
      end
      1: c = uniform_cfg(9'd1);
      3: begin
        // raw bits, out-of-range values included
        c.grid_cols  = 9'($urandom_range(0, 511));
        c.out_tile_w = 9'($urandom_range(0, 511));
        c.out_tile_h = 9'($urandom_range(0, 511));
        c.src_tile_w = 9'($urandom_range(0, 511));
        c.src_tile_h = 9'($urandom_range(0, 511));
        c.tex_cols   = 9'($urandom_range(0, 511));
      end
      4: c.grid_cols = 9'($urandom_range(2, 8));
      5: c = uniform_cfg(9'd0);
      6: c = uniform_cfg(9'h1ff);
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [tqvg_pkg::TileW-1:0] pick_tile(input int unsigned empty_pct);
    int unsigned                 r;
    logic [tqvg_pkg::TileW-1:0] v;
    r = $urandom_range(99);
    if (r < empty_pct) begin
      v = '0;
    end else if (r < empty_pct + 25) begin
      v = 12'($urandom_range(1, 40));
    end else if (r < empty_pct + 33) begin
      v = 12'(tqvg_pkg::MaxTileValue);
    end else begin
      v = 12'($urandom_range(1, 4095));
    end
    return v;
  endfunction

  initial begin
    tqvg_pkg::cfg_t c;
    int unsigned    p, i, empty_pct;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    tiles_sent     = 0;
    cfg_loads      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed tiles under the reset registers
    send_tile(12'd1, 1'b1);
    send_tile(12'd0, 1'b0);
    send_tile(12'd2, 1'b0);
    send_tile(12'd16, 1'b0);
    send_tile(12'd17, 1'b0);
    send_tile(12'hfff, 1'b0);
    send_tile(12'hffe, 1'b0);
    send_tile(12'haaa, 1'b0);
    send_tile(12'h555, 1'b0);
    send_tile(12'd0, 1'b0);
    send_tile(12'd0, 1'b0);
    send_tile(12'd100, 1'b0);
    send_tile(12'd3, 1'b1);
    send_tile(12'd0, 1'b0);
    send_tile(12'd33, 1'b0);
    drain();

    // shrink the grid below the current column: one tile there, then wrap
    c = uniform_cfg(9'd16);
    c.grid_cols = 9'd3;
    load_config(c);
    send_tile(12'd5, 1'b0);
    send_tile(12'd6, 1'b0);
    send_tile(12'd7, 1'b0);
    drain();

    // widest registers: last texture column and the largest tile
    load_config(uniform_cfg(9'd256));
    send_tile(12'd256, 1'b1);
    send_tile(12'd0, 1'b0);
    send_tile(12'd256, 1'b0);
    send_tile(12'hfff, 1'b0);
    drain();

    for (p = 0; p < RandPhases; p++) begin
      load_config(pick_config(p));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct = 29; recv_stall_pct <= 29; end
      endcase
      empty_pct = 30;
      if (p == 4) begin
        // stall the output for a long stretch while tiles keep coming
        hold_go   <= 1'b1;
        empty_pct = 5;
      end
      for (i = 0; i < PhaseItems; i++) begin
        send_tile(pick_tile(empty_pct), ($urandom_range(19) == 0));
      end
      drain();
    end

    $display("Sent %0d tile requests over %0d register settings and four idling modes,",
             tiles_sent, cfg_loads);
    $display("including a shrunk grid, the widest registers and a long output hold-off;"
             , " %0d vertices compared.", vtx_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d vertices outstanding", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tqvg_pkg.sv
design/tqvg_front.sv
design/tqvg_fifo.sv
design/tqvg_div.sv
design/tqvg_back.sv
design/tilemap_quad_vertex_generator_unit.sv
sim/tilemap_quad_vertex_generator_checker.sv
sim/tilemap_quad_vertex_generator_unit_test.sv
